@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ src/mlfq_pkg.sv @@
`default_nettype none

package mlfq_pkg;

  localparam int ID_W      = 8;
  localparam int TIME_W    = 16;
  localparam int FUNC_W    = 2;
  localparam int SEL_LVL_W = 2;

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_REQUEUE = 2'd1,
    FUNC_SELECT  = 2'd2,
    FUNC_CHECK   = 2'd3
  } func_t;

  // One result word.
  typedef struct packed {
    logic                 found;
    logic [ID_W-1:0]      selected_id;
    logic [SEL_LVL_W-1:0] selected_level;
    logic                 keep_running;
    logic                 none_waiting;
    logic                 status;
  } out_t;

endpackage

`default_nettype wire

@@ src/mlfq_in_if.sv @@
`default_nettype none

interface mlfq_in_if;
  logic                           valid;
  logic                           ready;
  logic [mlfq_pkg::FUNC_W-1:0]    func;
  logic [mlfq_pkg::ID_W-1:0]      process_id;
  logic [mlfq_pkg::TIME_W-1:0]    service_time;
  logic [mlfq_pkg::TIME_W-1:0]    done_time;
  logic [mlfq_pkg::TIME_W-1:0]    selected_time;
  logic [mlfq_pkg::TIME_W-1:0]    current_time;

  modport source (
    output valid, func, process_id, service_time, done_time, selected_time, current_time,
    input  ready
  );

  modport sink (
    input  valid, func, process_id, service_time, done_time, selected_time, current_time,
    output ready
  );
endinterface

`default_nettype wire

@@ src/mlfq_out_if.sv @@
`default_nettype none

interface mlfq_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [mlfq_pkg::ID_W-1:0]        selected_id;
  logic [mlfq_pkg::SEL_LVL_W-1:0]   selected_level;
  logic                             keep_running;
  logic                             none_waiting;
  logic                             status;

  modport source (
    output valid, found, selected_id, selected_level, keep_running, none_waiting, status,
    input  ready
  );

  modport sink (
    input  valid, found, selected_id, selected_level, keep_running, none_waiting, status,
    output ready
  );
endinterface

`default_nettype wire

@@ src/multilevel_feedback_queue_scheduler.sv @@
// Channel   Role  Handshake     Word
// in_chan   sink  valid/ready   func, process_id, service_time, done_time,
//                               selected_time, current_time
// out_chan  src   valid/ready   found, selected_id, selected_level,
//                               keep_running, none_waiting, status
//
// Insert, requeue and check load the output register directly; a select first
// reads the id from the single FIFO store, whose read is registered.
// A new word is taken when the output register is empty or drains in that
// cycle; a select also holds the input off during its store read.
// Synchronous active-low reset empties all queues and clears the running level.
// No clearing pass is needed: the store is read only where it was written.
`default_nettype none
`include "assert_macros.svh"

module multilevel_feedback_queue_scheduler #(
  parameter int LOWEST_LEVEL = 3,
  parameter int QUEUE_DEPTH  = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  mlfq_in_if.sink    in_chan,
  mlfq_out_if.source out_chan
);

  localparam int NUM_LEVELS = LOWEST_LEVEL + 1;
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W     = LVL_W + PTR_W;
  localparam int MEM_DEPTH  = NUM_LEVELS * (1 << PTR_W);
  localparam int TIME_W     = mlfq_pkg::TIME_W;
  localparam int ID_W       = mlfq_pkg::ID_W;
  localparam int SEL_LVL_W  = mlfq_pkg::SEL_LVL_W;

  typedef enum logic {ST_IDLE, ST_RD} state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  mlfq_pkg::out_t      out_r;
  logic [PTR_W-1:0]    head_r [NUM_LEVELS];
  logic [PTR_W-1:0]    tail_r [NUM_LEVELS];
  logic [FILL_W-1:0]   fill_r [NUM_LEVELS];
  logic [PTR_W-1:0]    head_nxt [NUM_LEVELS];
  logic [PTR_W-1:0]    tail_nxt [NUM_LEVELS];
  logic [FILL_W-1:0]   fill_nxt [NUM_LEVELS];
  logic [LVL_W-1:0]    run_lvl_r, run_lvl_nxt;
  logic                run_vld_r, run_vld_nxt;

  // Select result held while the store read completes.
  logic                pend_found_r;
  logic [SEL_LVL_W-1:0] pend_lvl_r;
  logic                pend_nw_r;

  // FIFO store.
  logic [ID_W-1:0]     mem [MEM_DEPTH];
  logic [ID_W-1:0]     rd_data_r;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   waddr, raddr;

  logic                acc;
  mlfq_pkg::func_t     func;
  logic [LVL_W-1:0]    push_lvl;
  logic                push_full;
  logic [LVL_W-1:0]    pop_lvl;
  logic                any_waiting;
  logic                nw_after;
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W:0]     used_sum;
  logic                keep;
  logic [LVL_W+SEL_LVL_W-1:0] pop_lvl_ext;
  mlfq_pkg::out_t      acc_out;

  assign func = mlfq_pkg::func_t'(in_chan.func);
  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign acc = in_chan.valid && in_chan.ready;

  // Target level of an insert or a requeue.
  always_comb begin
    if (func == mlfq_pkg::FUNC_INSERT || !run_vld_r) begin
      push_lvl = '0;
    end else if (run_lvl_r == LVL_W'(LOWEST_LEVEL)) begin
      push_lvl = LVL_W'(LOWEST_LEVEL);
    end else begin
      push_lvl = run_lvl_r + LVL_W'(1);
    end
  end
  assign push_full = (fill_r[push_lvl] == FILL_W'(QUEUE_DEPTH));

  // Highest-priority non-empty level.
  always_comb begin
    pop_lvl     = '0;
    any_waiting = 1'b0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (fill_r[i] != '0) begin
        pop_lvl     = LVL_W'(i);
        any_waiting = 1'b1;
      end
    end
  end
  assign pop_lvl_ext = {{SEL_LVL_W{1'b0}}, pop_lvl};

  // Run check: stop when finished, else keep running inside the level's quantum, or without limit at the lowest level.
  assign elapsed  = in_chan.current_time - in_chan.selected_time;
  assign used_sum = {1'b0, in_chan.done_time} + {1'b0, elapsed};
  always_comb begin
    if (!run_vld_r || used_sum == {1'b0, in_chan.service_time}) begin
      keep = 1'b0;
    end else if (run_lvl_r == LVL_W'(LOWEST_LEVEL)) begin
      keep = 1'b1;
    end else begin
      keep = ((elapsed >> run_lvl_r) == '0);
    end
  end

  // Next-state logic for pointers, fill counts, running level and control.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    run_lvl_nxt   = run_lvl_r;
    run_vld_nxt   = run_vld_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = {push_lvl, tail_r[push_lvl]};
    raddr         = {pop_lvl, head_r[pop_lvl]};
    acc_out       = '0;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (func)
            mlfq_pkg::FUNC_INSERT, mlfq_pkg::FUNC_REQUEUE: begin
              out_valid_nxt = 1'b1;
              if (push_full) begin
                acc_out.status = 1'b1;
              end else begin
                mem_we             = 1'b1;
                tail_nxt[push_lvl] = (tail_r[push_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : tail_r[push_lvl] + PTR_W'(1);
                fill_nxt[push_lvl] = fill_r[push_lvl] + FILL_W'(1);
              end
            end
            mlfq_pkg::FUNC_SELECT: begin
              state_nxt = ST_RD;
              if (any_waiting) begin
                mem_re            = 1'b1;
                head_nxt[pop_lvl] = (head_r[pop_lvl] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : head_r[pop_lvl] + PTR_W'(1);
                fill_nxt[pop_lvl] = fill_r[pop_lvl] - FILL_W'(1);
                run_lvl_nxt       = pop_lvl;
                run_vld_nxt       = 1'b1;
              end
            end
            default: begin
              out_valid_nxt        = 1'b1;
              acc_out.keep_running = keep;
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    nw_after = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (fill_nxt[i] != '0) begin
        nw_after = 1'b0;
      end
    end
    acc_out.none_waiting = nw_after;
  end

  // Control state, pointers, fill counts, running level, result word and pending select fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      out_r        <= '0;
      run_lvl_r    <= '0;
      run_vld_r    <= 1'b0;
      pend_found_r <= 1'b0;
      pend_lvl_r   <= '0;
      pend_nw_r    <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      run_lvl_r   <= run_lvl_nxt;
      run_vld_r   <= run_vld_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      if (acc && func == mlfq_pkg::FUNC_SELECT) begin
        pend_found_r <= any_waiting;
        pend_lvl_r   <= any_waiting ? pop_lvl_ext[SEL_LVL_W-1:0] : '0;
        pend_nw_r    <= nw_after;
      end
      if (acc && func != mlfq_pkg::FUNC_SELECT) begin
        out_r <= acc_out;
      end else if (state_r == ST_RD) begin
        out_r.found          <= pend_found_r;
        out_r.selected_id    <= pend_found_r ? rd_data_r : '0;
        out_r.selected_level <= pend_lvl_r;
        out_r.keep_running   <= 1'b0;
        out_r.none_waiting   <= pend_nw_r;
        out_r.status         <= 1'b0;
      end
    end
  end

  // FIFO store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_chan.process_id;
    end
    if (mem_re) begin
      rd_data_r <= mem[raddr];
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.found          = out_r.found;
  assign out_chan.selected_id    = out_r.selected_id;
  assign out_chan.selected_level = out_r.selected_level;
  assign out_chan.keep_running   = out_r.keep_running;
  assign out_chan.none_waiting   = out_r.none_waiting;
  assign out_chan.status         = out_r.status;

  // The select store-read state always produces its result in the following cycle.
  `ASSERT_CLK(a_rd_loads_out, clk, rst_n, (state_r == ST_RD) |=> out_valid_r,
              "select result missing")
  // A select that finds a process records a running level.
  `ASSERT_CLK(a_sel_sets_level, clk, rst_n,
              (acc && func == mlfq_pkg::FUNC_SELECT && any_waiting) |=>
              (run_vld_r && out_valid_r == 1'b0 && state_r == ST_RD),
              "select did not record level")
  // Insert, requeue and check finish in idle with a result ready.
  `ASSERT_CLK(a_short_op, clk, rst_n,
              (acc && func != mlfq_pkg::FUNC_SELECT) |=> (out_valid_r && state_r == ST_IDLE),
              "one-cycle operation lost")
  // A word is never taken while the select read is outstanding.
  `ASSERT_NEVER(a_no_acc_in_rd, clk, rst_n, acc && state_r == ST_RD,
                "word accepted during store read")

endmodule

`default_nettype wire
